@@ sv/mlft_pkg.sv @@
`default_nettype none

package mlft_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 48;
    localparam int TIME_W        = 32;
    localparam int AGE_W         = 16;
    localparam int COUNT_W       = 9;
    localparam int MASK_W        = 2;
    localparam int MCAST_BIT     = 40;

    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [AGE_W-1:0]   AGE_RESET   = AGE_W'(300);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [MASK_W-1:0]  FLOOD_MASK  = 2'b11;
    localparam logic [MASK_W-1:0]  BYPASS_MASK = 2'b01;

    // configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_AGE  = 1'b1;

    typedef enum logic [1:0] {
        FN_FRAME = 2'd0,
        FN_TICK  = 2'd1,
        FN_SWEEP = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LEARN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              port;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [COUNT_W-1:0] aged;
        logic               dropped;
        logic               learned;
        logic               hit;
        logic [MASK_W-1:0]  mask;
    } t_result;

endpackage

`default_nettype wire

@@ sv/mac_learning_forwarding_table.sv @@
// layer-2 learning and forwarding table with aging
//
// input stream (s_axis): one request per frame, time tick or aging sweep;
//   tuser carries func, tdata the source address, destination address and port
// output stream (m_axis): one result per frame or sweep, none for a tick or the
//   unused func code; tdata carries mask, hit, learned, dropped and aged count
// config port: write enable, register index (0 mode, 1 age limit), 16-bit data;
//   the user must write it only while the block is idle; the block does not enforce this
//
// a frame with the table in use or a sweep walks all 256 entries through one
//   registered read port, one entry a cycle, with one shared match / age stage;
//   a frame then takes a learn step, and the result loads the output register
//   from the done state; the next request is taken once the block is idle again
// in bypass mode a frame gives mask 1 from the done state, with no walk;
//   a tick stays idle and gives no result
// reset clears the valid bits, the time counter and the mode, and sets the age limit to 300, at once
// when the receiver stalls, a finished result waits in the output register; the
//   next request is still taken and runs, then waits for the register to drain
`default_nettype none

module mac_learning_forwarding_table
    import mlft_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // func[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    // source_address[47:0], destination_address[95:48], source_port[96],
    // zero pad[103:97]
    input  wire logic [103:0] i_s_axis_tdata,

    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // destination_mask[1:0], lookup_hit[2], learned_new[3],
    // learn_dropped[4], aged_count[13:5], zero pad[15:14]
    output logic [15:0]       o_m_axis_tdata,

    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);

    t_state r_state, n_state;

    // config
    logic             r_mode;
    logic [AGE_W-1:0] r_age_limit;

    logic [TIME_W-1:0] r_time;

    // captured request
    t_func             r_func;
    logic [ADDR_W-1:0] r_src;
    logic [ADDR_W-1:0] r_dst;
    logic              r_port;

    // entry store
    t_entry r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    // walk pipeline: read stage then check stage
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_on;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_chk_on;
    t_entry           r_q;

    // walk findings
    logic             r_src_found;
    logic [IDX_W-1:0] r_src_slot;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_slot;
    logic             r_dst_found;
    logic             r_dst_port;
    logic [COUNT_W-1:0] r_aged;

    // output register
    logic    r_out_valid;
    t_result r_res;

    logic in_acc;
    logic walk_last;
    logic chk_valid;
    logic src_match, dst_match;
    logic [TIME_W-1:0] age_diff;
    logic expire;
    logic [COUNT_W-1:0] aged_next;
    logic out_free;
    logic learn_ok;
    logic [IDX_W-1:0] learn_slot;
    t_result n_res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign walk_last       = r_chk_on && (r_chk_idx == LAST_IDX);
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // shared check unit: address match and wrapped age compare
    assign chk_valid = r_valid[r_chk_idx];
    assign src_match = chk_valid && (r_q.addr == r_src);
    assign dst_match = chk_valid && (r_q.addr == r_dst);
    assign age_diff  = r_q.stamp + TIME_W'(r_age_limit) - r_time;
    assign expire    = chk_valid && age_diff[TIME_W-1];
    assign aged_next = (expire && r_aged != COUNT_MAX) ? r_aged + 1'b1 : r_aged;

    assign learn_ok   = r_src_found || r_free_found;
    assign learn_slot = r_src_found ? r_src_slot : r_free_slot;

    // frame result, formed in the learn step
    always_comb begin
        n_res         = '0;
        n_res.learned = !r_src_found && r_free_found;
        n_res.dropped = !learn_ok;
        if (r_dst[MCAST_BIT]) begin
            n_res.mask = FLOOD_MASK;
        end else if (r_dst == r_src) begin
            // the learn just made or refreshed this very entry
            n_res.hit  = learn_ok;
            n_res.mask = learn_ok ? MASK_W'(1) << r_port : FLOOD_MASK;
        end else begin
            n_res.hit  = r_dst_found;
            n_res.mask = r_dst_found ? MASK_W'(1) << r_dst_port : FLOOD_MASK;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_func'(i_s_axis_tuser))
                        FN_FRAME: n_state = r_mode ? S_WALK : S_DONE;
                        FN_SWEEP: n_state = S_WALK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = (r_func == FN_SWEEP) ? S_DONE : S_LEARN;
                end
            end
            S_LEARN: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // config and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_age_limit <= AGE_RESET;
            r_time      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE: r_mode      <= i_cfg_data[0];
                    CFG_AGE:  r_age_limit <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (in_acc && t_func'(i_s_axis_tuser) == FN_TICK) begin
                r_time <= r_time + 1'b1;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= t_func'(i_s_axis_tuser);
            r_src  <= i_s_axis_tdata[47:0];
            r_dst  <= i_s_axis_tdata[95:48];
            r_port <= i_s_axis_tdata[96];
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_LEARN && learn_ok) begin
            r_mem[learn_slot] <= '{addr: r_src, port: r_port, stamp: r_time};
        end
        if (r_rd_on) begin
            r_q <= r_mem[r_rd_idx];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == S_LEARN && learn_ok) begin
            r_valid[learn_slot] <= 1'b1;
        end else if (r_state == S_WALK && r_chk_on && r_func == FN_SWEEP && expire) begin
            r_valid[r_chk_idx] <= 1'b0;
        end
    end

    // walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_on  <= 1'b0;
            r_chk_on <= 1'b0;
        end else begin
            r_chk_on <= r_rd_on;
            if (r_state == S_IDLE && n_state == S_WALK) begin
                r_rd_on <= 1'b1;
            end else if (r_rd_on && r_rd_idx == LAST_IDX) begin
                r_rd_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rd_idx <= '0;
        end else if (r_rd_on) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_chk_idx <= r_rd_idx;
    end

    // walk findings, first match wins
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_src_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_dst_found  <= 1'b0;
            r_aged       <= '0;
        end else if (r_state == S_WALK && r_chk_on) begin
            r_aged <= aged_next;
            if (src_match && !r_src_found) begin
                r_src_found <= 1'b1;
                r_src_slot  <= r_chk_idx;
            end
            if (!chk_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_chk_idx;
            end
            if (dst_match && !r_dst_found) begin
                r_dst_found <= 1'b1;
                r_dst_port  <= r_q.port;
            end
        end
    end

    // result staging
    t_result r_pend;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_pend      <= '0;
            r_pend.mask <= BYPASS_MASK;
        end else if (r_state == S_WALK && walk_last && r_func == FN_SWEEP) begin
            r_pend      <= '0;
            r_pend.aged <= aged_next;
        end else if (r_state == S_LEARN) begin
            r_pend <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_res <= r_pend;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_res.aged, r_res.dropped, r_res.learned,
                              r_res.hit, r_res.mask};

endmodule

`default_nettype wire

@@ dv/forwarding_checker.sv @@
module forwarding_checker
    import mlft_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    // func[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    // source_address[47:0], destination_address[95:48], source_port[96],
    // zero pad[103:97]
    input  wire logic [103:0] i_s_axis_tdata,

    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // destination_mask[1:0], lookup_hit[2], learned_new[3],
    // learn_dropped[4], aged_count[13:5], zero pad[15:14]
    input  wire logic [15:0]  i_m_axis_tdata,

    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data,

    output int                o_failures,
    output int                o_outstanding
);

    // own copy of the station table and the registers
    logic              slot_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_addr  [TABLE_ENTRIES];
    logic              slot_port  [TABLE_ENTRIES];
    logic [TIME_W-1:0] slot_stamp [TABLE_ENTRIES];
    logic [TIME_W-1:0] clock_now;
    logic              mode_on;
    logic [AGE_W-1:0]  age_limit;

    t_result expected_results [$];
    t_result got;
    t_result want;
    t_result fresh;
    int      failures;
    int      pending_count;

    assign o_failures    = failures;
    assign o_outstanding = pending_count;

    initial begin
        failures      = 0;
        pending_count = 0;
    end

    function automatic int find_station(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i] && slot_addr[i] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    // returns 1 when the request yields a result
    function automatic bit predict_forwarding(input logic [1:0] fn,
                                              input logic [103:0] req,
                                              output t_result res);
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] da;
        logic              sp;
        logic [TIME_W-1:0] margin;
        int                slot;
        int                free_slot;
        sa  = req[47:0];
        da  = req[95:48];
        sp  = req[96];
        res = '0;
        case (fn)
            FN_TICK: begin
                clock_now = clock_now + 1'b1;
                return 1'b0;
            end
            FN_SWEEP: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (slot_valid[i]) begin
                        margin = slot_stamp[i] + TIME_W'(age_limit) - clock_now;
                        if (margin[TIME_W-1]) begin
                            slot_valid[i] = 1'b0;
                            if (res.aged != COUNT_MAX) begin
                                res.aged = res.aged + 1'b1;
                            end
                        end
                    end
                end
                return 1'b1;
            end
            FN_FRAME: begin
                if (!mode_on) begin
                    res.mask = BYPASS_MASK;
                    return 1'b1;
                end
                slot = find_station(sa);
                if (slot >= 0) begin
                    slot_port[slot]  = sp;
                    slot_stamp[slot] = clock_now;
                end else begin
                    free_slot = -1;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                        if (!slot_valid[i]) begin
                            free_slot = i;
                        end
                    end
                    if (free_slot >= 0) begin
                        slot_valid[free_slot] = 1'b1;
                        slot_addr[free_slot]  = sa;
                        slot_port[free_slot]  = sp;
                        slot_stamp[free_slot] = clock_now;
                        res.learned = 1'b1;
                    end else begin
                        res.dropped = 1'b1;
                    end
                end
                if (da[MCAST_BIT]) begin
                    res.mask = FLOOD_MASK;
                end else begin
                    slot = find_station(da);
                    if (slot >= 0) begin
                        res.mask = MASK_W'(1) << slot_port[slot];
                        res.hit  = 1'b1;
                    end else begin
                        res.mask = FLOOD_MASK;
                    end
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
            end
            clock_now = '0;
            mode_on   = 1'b0;
            age_limit = AGE_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MODE) begin
                    mode_on = i_cfg_data[0];
                end else begin
                    age_limit = i_cfg_data;
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(i_m_axis_tdata[13:0]);
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", i_m_axis_tdata);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("destination_mask", int'(want.mask), int'(got.mask));
                    check_field("lookup_hit", int'(want.hit), int'(got.hit));
                    check_field("learned_new", int'(want.learned), int'(got.learned));
                    check_field("learn_dropped", int'(want.dropped), int'(got.dropped));
                    check_field("aged_count", int'(want.aged), int'(got.aged));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (predict_forwarding(i_s_axis_tuser, i_s_axis_tdata, fresh)) begin
                    expected_results.push_back(fresh);
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

@@ dv/tb.sv @@
module tb;
    import mlft_pkg::*;

    // the one func code the block ignores
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // long enough for a frame to walk the whole table, so this covers one in flight
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEM_BUDGET   = 1150;
    localparam int STATIONS      = 12;
    // receiver hold-off long enough for a result to park and the next to finish
    localparam int HOLD_CYCLES   = 1500;

    localparam logic [ADDR_W-1:0] ALL_ONES    = {ADDR_W{1'b1}};
    localparam logic [ADDR_W-1:0] GROUP_ADDR  = 48'h01005E000001;

    logic         clk        = 1'b0;
    logic         rst_n      = 1'b0;

    logic         s_tvalid   = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser    = '0;
    logic [103:0] s_tdata    = '0;

    logic         m_tvalid;
    logic         m_tready   = 1'b0;
    logic [15:0]  m_tdata;

    logic         cfg_we     = 1'b0;
    logic         cfg_idx    = CFG_MODE;
    logic [15:0]  cfg_data   = '0;

    int           failures;
    int           outstanding;

    // stimulus bookkeeping
    int           sent       = 0;
    bit           tx_burst   = 1'b0;
    bit           rx_burst   = 1'b0;
    logic         rx_hold    = 1'b0;

    // a handful of unicast stations so that lookups find learned entries
    logic [ADDR_W-1:0] known [STATIONS];

    mac_learning_forwarding_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    forwarding_checker fwd_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] any_address();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // offer one request after a random gap (none in a burst) and hold it until taken
    // every task returns just after a rising edge
    task automatic offer(input logic [1:0] fn, input logic [ADDR_W-1:0] sa,
                         input logic [ADDR_W-1:0] da, input logic sp);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'b0, sp, da, sa};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (fn != FN_UNUSED) begin
            sent++;
        end
    endtask

    // stop offering, wait for every expected result, then wait out the settle time
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers only change while the block is idle
    task automatic reconfigure(input logic mode, input logic [AGE_W-1:0] age);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MODE;
        cfg_data <= {15'b0, mode};
        @(posedge clk);
        cfg_idx  <= CFG_AGE;
        cfg_data <= age;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // receiver: random stalls, bursts with none, and one long hold-off
    initial begin : result_sink
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) begin
                rx_burst = !rx_burst;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 12);
            if (gap > 0 || rx_hold) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // long receiver stall while requests keep coming, so the output register
    // fills, the next walk completes behind it and the input stalls
    initial begin : long_hold
        wait (sent >= 450);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial begin : stimulus
        logic [1:0]        fn;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic              mode_pick;
        logic [AGE_W-1:0]  age_pick;
        int                phase_len;
        int                r;
        int                roll;

        for (int i = 0; i < STATIONS; i++) begin
            known[i]            = any_address();
            known[i][MCAST_BIT] = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass mode straight out of reset: mask 1 whatever the addresses
        offer(FN_FRAME, any_address(), any_address(), 1'b1);
        offer(FN_FRAME, ALL_ONES, ALL_ONES, 1'b0);
        offer(FN_TICK, '0, '0, 1'b0);
        offer(FN_UNUSED, any_address(), any_address(), 1'b1);
        // sweep of an empty table, which also runs in bypass mode
        offer(FN_SWEEP, '0, '0, 1'b0);

        // learning on with a short age limit
        reconfigure(1'b1, AGE_W'(2));
        offer(FN_FRAME, known[0], known[1], 1'b0);      // learn, miss floods
        offer(FN_FRAME, known[1], known[0], 1'b1);      // learn, hit on port 0
        offer(FN_FRAME, known[0], known[1], 1'b1);      // refresh, hit on port 1
        offer(FN_FRAME, '0, GROUP_ADDR, 1'b0);          // multicast floods
        offer(FN_FRAME, ALL_ONES, '0, 1'b1);            // hit on the zero address
        offer(FN_FRAME, known[2], ALL_ONES, 1'b0);      // broadcast floods
        offer(FN_UNUSED, any_address(), any_address(), 1'b0);
        repeat (3) offer(FN_TICK, '0, '0, 1'b0);
        offer(FN_SWEEP, '0, '0, 1'b0);                  // everything has expired
        offer(FN_FRAME, known[0], known[1], 1'b0);      // learned afresh

        // age limit of zero: an entry lasts only until the next tick
        reconfigure(1'b1, '0);
        offer(FN_FRAME, known[1], known[0], 1'b1);
        offer(FN_SWEEP, '0, '0, 1'b0);
        offer(FN_TICK, '0, '0, 1'b0);
        offer(FN_SWEEP, '0, '0, 1'b0);

        // empty the table, then fill it past capacity so learns get dropped
        reconfigure(1'b1, AGE_W'(1));
        repeat (3) offer(FN_TICK, '0, '0, 1'b0);
        offer(FN_SWEEP, '0, '0, 1'b0);
        reconfigure(1'b1, '1);
        for (int k = 0; k < TABLE_ENTRIES + 6; k++) begin
            if (k % 32 == 31) begin
                offer(FN_TICK, '0, '0, 1'b0);
            end
            offer(FN_FRAME, {8'h02, 24'hC0FFEE, 16'(k)}, {8'h02, 24'hC0FFEE, 16'(k / 2)},
                  k[0]);
        end
        // full table: a known source still refreshes instead of dropping
        offer(FN_FRAME, {8'h02, 24'hC0FFEE, 16'd3}, {8'h02, 24'hC0FFEE, 16'd300}, 1'b1);
        // the older entries age out first, the rest after more ticks
        reconfigure(1'b1, AGE_W'(6));
        repeat (4) offer(FN_TICK, '0, '0, 1'b0);
        offer(FN_SWEEP, '0, '0, 1'b0);
        repeat (8) offer(FN_TICK, '0, '0, 1'b0);
        offer(FN_SWEEP, '0, '0, 1'b0);

        // random phases, each with its own setting of the registers
        while (sent < ITEM_BUDGET) begin
            mode_pick = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0:       age_pick = AGE_W'(1);
                1:       age_pick = AGE_W'(2);
                2:       age_pick = AGE_W'(3);
                3:       age_pick = AGE_W'(5);
                4:       age_pick = AGE_W'(8);
                5:       age_pick = AGE_RESET;
                6:       age_pick = '1;
                default: age_pick = AGE_W'($urandom_range(1, 65535));
            endcase
            reconfigure(mode_pick, age_pick);
            tx_burst  = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) begin
                r    = $urandom_range(0, 99);
                roll = $urandom_range(0, 99);
                src  = ($urandom_range(0, 4) != 0) ? known[$urandom_range(0, STATIONS - 1)]
                                                   : any_address();
                if (roll < 60) begin
                    dst = known[$urandom_range(0, STATIONS - 1)];
                end else begin
                    dst = any_address();
                    if (roll < 75) begin
                        dst[MCAST_BIT] = 1'b1;
                    end
                end
                if (r < 3) begin
                    fn = FN_UNUSED;
                end else if (r < 21) begin
                    fn = FN_TICK;
                end else if (r < 27) begin
                    fn = FN_SWEEP;
                end else begin
                    fn = FN_FRAME;
                end
                offer(fn, src, dst, 1'($urandom_range(0, 1)));
            end
        end

        drain();
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
